// ===== src/lfu_pkg.sv =====
package lfu_pkg;

	localparam int PAGE_W     = 20;
	localparam int CFG_W      = 5;
	localparam int SLOT_OUT_W = 4;
	localparam int TOTAL_W    = 32;
	localparam int CLOCK_W    = 32;
	localparam int ACTIVE_RST = 16;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // latch request, advance clock, age counts
		logic look;     // tag compare, hit update or fill, scan setup
		logic scan;     // one victim-search step
		logic replace;  // install at chosen victim
	} lfu_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;
		logic fill;
		logic single;     // only one active slot, no search needed
		logic scan_last;  // current scan step covers the last active slot
	} lfu_sts_t;

endpackage

// ===== src/lfu_ctrl.sv =====
module lfu_ctrl import lfu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  lfu_sts_t sts,
	output lfu_cmd_t cmd,
	output logic     busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_REPL = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nx = ST_LOOK;
			end
			ST_LOOK: begin
				if (sts.hit || sts.fill) state_nx = ST_IDLE;
				else if (sts.single)     state_nx = ST_REPL;
				else                     state_nx = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_nx = ST_REPL;
			end
			ST_REPL: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign cmd.accept  = (state_q == ST_IDLE) && start;
	assign cmd.look    = (state_q == ST_LOOK);
	assign cmd.scan    = (state_q == ST_SCAN);
	assign cmd.replace = (state_q == ST_REPL);

endmodule

// ===== src/lfu_dp.sv =====
module lfu_dp import lfu_pkg::*; #(
	parameter int SLOTS        = 16,
	parameter int USE_BITS     = 16,
	parameter int AGING_PERIOD = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [PAGE_W-1:0]     page_number,
	input  logic                  write_access,
	input  lfu_cmd_t              cmd,
	output lfu_sts_t              sts,
	output logic                  done,
	output logic                  hit,
	output logic [SLOT_OUT_W-1:0] slot_used,
	output logic                  evicted,
	output logic [TOTAL_W-1:0]    hit_total,
	output logic [TOTAL_W-1:0]    miss_total
);

	localparam int IW    = $clog2(SLOTS);
	localparam int NW    = $clog2(SLOTS + 1);
	localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
	localparam int PW    = $clog2(AGING_PERIOD);
	localparam int KW    = USE_BITS + CLOCK_W;
	localparam int N_RST = (SLOTS < ACTIVE_RST) ? SLOTS : ACTIVE_RST;

	// slot store
	logic [PAGE_W-1:0]   slot_page_q  [SLOTS];
	logic                slot_valid_q [SLOTS];
	logic                slot_dirty_q [SLOTS];
	logic [USE_BITS-1:0] slot_uses_q  [SLOTS];
	logic [CLOCK_W-1:0]  slot_stamp_q [SLOTS];

	logic [NW-1:0]       active_q;
	logic [NW-1:0]       filled_q;
	logic [CLOCK_W-1:0]  clock_q;
	logic [PW-1:0]       phase_q;
	logic [PAGE_W-1:0]   page_q;
	logic                wr_q;
	logic [TOTAL_W-1:0]  hits_q;
	logic [TOTAL_W-1:0]  misses_q;

	logic [IW-1:0]       scan_idx_q;
	logic [IW-1:0]       best_idx_q;
	logic [KW-1:0]       best_key_q;

	logic                done_q;
	logic                hit_q;
	logic [IW-1:0]       slot_q;
	logic                evicted_q;

	logic [CW-1:0]       cfg_ext;
	logic [NW-1:0]       cfg_clamped;
	logic [CLOCK_W-1:0]  clock_nx;
	logic [PW-1:0]       phase_nx;
	logic                age_now;
	logic [SLOTS-1:0]    active_vec;
	logic                hit_any;
	logic [IW-1:0]       hit_idx;
	logic                empty_any;
	logic [IW-1:0]       empty_idx;
	logic                fill_ok;
	logic [KW-1:0]       scan_key;
	logic                scan_better;
	logic                vict_valid;

	// register clamp: zero reads as one, above SLOTS reads as SLOTS
	always_comb begin
		cfg_ext = CW'(cfg_data);
		if (cfg_ext == '0)                cfg_clamped = NW'(1);
		else if (cfg_ext > CW'(SLOTS))    cfg_clamped = NW'(SLOTS);
		else                              cfg_clamped = NW'(cfg_ext);
	end

	// phase tracks clock mod period; a wrapped clock restarts it
	always_comb begin
		clock_nx = clock_q + CLOCK_W'(1);
		if (clock_nx == '0)                       phase_nx = '0;
		else if (phase_q == PW'(AGING_PERIOD - 1)) phase_nx = '0;
		else                                      phase_nx = phase_q + PW'(1);
		age_now = (clock_nx != '0) && (phase_nx == '0);
	end

	// tag compare and first free slot, lowest index wins
	always_comb begin
		hit_any   = 1'b0;
		hit_idx   = '0;
		empty_any = 1'b0;
		empty_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			active_vec[i] = (NW'(i) < active_q);
			if (active_vec[i] && slot_valid_q[i] && (slot_page_q[i] == page_q)) begin
				hit_any = 1'b1;
				hit_idx = IW'(i);
			end
			if (active_vec[i] && !slot_valid_q[i]) begin
				empty_any = 1'b1;
				empty_idx = IW'(i);
			end
		end
		fill_ok = (filled_q < active_q) && empty_any;
	end

	assign scan_key    = {slot_uses_q[scan_idx_q], slot_stamp_q[scan_idx_q]};
	assign scan_better = (scan_key < best_key_q);
	assign vict_valid  = slot_valid_q[best_idx_q];

	assign sts.hit       = hit_any;
	assign sts.fill      = fill_ok;
	assign sts.single    = (active_q == NW'(1));
	assign sts.scan_last = ((NW'(scan_idx_q) + NW'(1)) == active_q);

	// page tags: written on install only
	always_ff @(posedge clk) begin
		if (cmd.look && !hit_any && fill_ok) begin
			slot_page_q[empty_idx] <= page_q;
		end else if (cmd.replace) begin
			slot_page_q[best_idx_q] <= page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_valid_q[i] <= 1'b0;
				slot_dirty_q[i] <= 1'b0;
				slot_uses_q[i]  <= '0;
				slot_stamp_q[i] <= '0;
			end
			active_q  <= NW'(N_RST);
			filled_q  <= '0;
			clock_q   <= '0;
			phase_q   <= '0;
			hits_q    <= '0;
			misses_q  <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				active_q <= cfg_clamped;
			end
			if (cmd.accept) begin
				clock_q <= clock_nx;
				phase_q <= phase_nx;
				if (age_now) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (active_vec[i] && slot_valid_q[i]) begin
							slot_uses_q[i] <= slot_uses_q[i] >> 1;
						end
					end
				end
			end
			if (cmd.look) begin
				if (hit_any) begin
					hits_q <= hits_q + TOTAL_W'(1);
					if (slot_uses_q[hit_idx] != '1) begin
						slot_uses_q[hit_idx] <= slot_uses_q[hit_idx] + USE_BITS'(1);
					end
					slot_stamp_q[hit_idx] <= clock_q;
					if (wr_q) slot_dirty_q[hit_idx] <= 1'b1;
					done_q <= 1'b1;
				end else begin
					misses_q <= misses_q + TOTAL_W'(1);
					if (fill_ok) begin
						slot_valid_q[empty_idx] <= 1'b1;
						slot_dirty_q[empty_idx] <= wr_q;
						slot_uses_q[empty_idx]  <= USE_BITS'(1);
						slot_stamp_q[empty_idx] <= clock_q;
						if (filled_q != NW'(SLOTS)) filled_q <= filled_q + NW'(1);
						done_q <= 1'b1;
					end
				end
			end
			if (cmd.replace) begin
				slot_valid_q[best_idx_q] <= 1'b1;
				slot_dirty_q[best_idx_q] <= wr_q;
				slot_uses_q[best_idx_q]  <= USE_BITS'(1);
				slot_stamp_q[best_idx_q] <= clock_q;
				if (!vict_valid && (filled_q != NW'(SLOTS))) begin
					filled_q <= filled_q + NW'(1);
				end
				done_q <= 1'b1;
			end
		end
	end

	// request latch, victim search and result fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			page_q <= page_number;
			wr_q   <= write_access;
		end
		if (cmd.look) begin
			scan_idx_q <= IW'(1);
			best_idx_q <= '0;
			best_key_q <= {slot_uses_q[0], slot_stamp_q[0]};
			hit_q      <= hit_any;
			evicted_q  <= 1'b0;
			slot_q     <= hit_any ? hit_idx : empty_idx;
		end
		if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + IW'(1);
			if (scan_better) begin
				best_idx_q <= scan_idx_q;
				best_key_q <= scan_key;
			end
		end
		if (cmd.replace) begin
			hit_q     <= 1'b0;
			evicted_q <= vict_valid;
			slot_q    <= best_idx_q;
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign slot_used  = SLOT_OUT_W'(slot_q);
	assign evicted    = evicted_q;
	assign hit_total  = hits_q;
	assign miss_total = misses_q;

endmodule

// ===== src/lfu_cache_replacement.sv =====
// Channel   | Ports                                        | Transfer
// ----------+----------------------------------------------+---------------------------------
// config    | cfg_we, cfg_data                             | edge with cfg_we high
// request   | start, busy, page_number, write_access       | edge with start high, busy low
// result    | done, hit, slot_used, evicted, hit/miss_total | edge ending the done cycle
//
// Hit or fill: accept, then tag compare and update in the look state.
// Replacement: after the look state, the LFU victim search walks one slot a cycle
// through a single (use count, stamp) comparator, then the replace state installs.
// Aging of all active valid slots happens in the accept cycle, in parallel.
// Reset clears the sequencer, the slot flags, counts and stamps, and the totals; no clearing pass.
// The result receiver cannot stall: done is a one-cycle strobe, fields hold after it.
module lfu_cache_replacement import lfu_pkg::*; #(
	parameter int SLOTS        = 16,
	parameter int USE_BITS     = 16,
	parameter int AGING_PERIOD = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  start,
	input  logic [PAGE_W-1:0]     page_number,
	input  logic                  write_access,
	output logic                  busy,
	output logic                  done,
	output logic                  hit,
	output logic [SLOT_OUT_W-1:0] slot_used,
	output logic                  evicted,
	output logic [TOTAL_W-1:0]    hit_total,
	output logic [TOTAL_W-1:0]    miss_total
);

	lfu_cmd_t cmd;
	lfu_sts_t sts;

	// sequencer: idle -> look -> (scan ...) -> replace
	lfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// slot store, tag compare, aging, victim search and totals
	lfu_dp #(
		.SLOTS        (SLOTS),
		.USE_BITS     (USE_BITS),
		.AGING_PERIOD (AGING_PERIOD)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.page_number  (page_number),
		.write_access (write_access),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.hit          (hit),
		.slot_used    (slot_used),
		.evicted      (evicted),
		.hit_total    (hit_total),
		.miss_total   (miss_total)
	);

endmodule

// ===== tb/lfu_cache_replacement_tb.sv =====
`timescale 1ns / 100ps

module lfu_cache_replacement_tb;
	import lfu_pkg::*;

	// Geometry of the block as instantiated (default parameters)
	localparam int SLOTS_N   = 16;
	localparam int AGE_EVERY = 8;
	localparam int DIR_N     = 22;
	localparam int PHASES    = 12;
	localparam int PHASE_LEN = 128;
	localparam int POOL_N    = 32;

	// One access outcome as seen on the result ports
	typedef struct packed {
		logic                  hit;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  evicted;
		logic [TOTAL_W-1:0]    hits;
		logic [TOTAL_W-1:0]    misses;
	} access_result_t;

	typedef enum logic {ROW_ACCESS, ROW_CFG} row_kind_t;

	// Directed stimulus row; "fixed" rows carry a hand-written outcome
	typedef struct packed {
		row_kind_t      kind;
		logic [CFG_W-1:0]  cfg_val;
		logic [PAGE_W-1:0] page;
		logic           wr;
		logic           fixed;
		access_result_t want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_W-1:0]      cfg_data;
	logic                  start;
	logic [PAGE_W-1:0]     page_number;
	logic                  write_access;
	logic                  busy;
	logic                  done;
	logic                  hit;
	logic [SLOT_OUT_W-1:0] slot_used;
	logic                  evicted;
	logic [TOTAL_W-1:0]    hit_total;
	logic [TOTAL_W-1:0]    miss_total;

	// Shadow copy of the slot store and counters
	logic [PAGE_W-1:0]  pg_tag   [SLOTS_N];
	logic               pg_valid [SLOTS_N];
	logic               pg_dirty [SLOTS_N];
	logic [15:0]        pg_uses  [SLOTS_N];
	logic [CLOCK_W-1:0] pg_stamp [SLOTS_N];
	logic [CLOCK_W-1:0] access_count;
	int                 fill_count;
	logic [TOTAL_W-1:0] hits_seen;
	logic [TOTAL_W-1:0] misses_seen;
	int                 slots_active;

	access_result_t outcome_q[$];
	stim_row_t      dir_rows [DIR_N];
	logic [PAGE_W-1:0] page_pool [POOL_N];
	int             err_count;

	lfu_cache_replacement dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.start       (start),
		.page_number (page_number),
		.write_access(write_access),
		.busy        (busy),
		.done        (done),
		.hit         (hit),
		.slot_used   (slot_used),
		.evicted     (evicted),
		.hit_total   (hit_total),
		.miss_total  (miss_total)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Fresh entry: count 1, stamped now, dirty from the write flag
	function automatic void place_page(input int idx, input logic [PAGE_W-1:0] pg, input logic wr);
		pg_tag[idx]   = pg;
		pg_valid[idx] = 1'b1;
		pg_dirty[idx] = wr;
		pg_uses[idx]  = 16'd1;
		pg_stamp[idx] = access_count;
	endfunction

	// LFU policy: age, look up, fill lowest empty, else evict min (count, stamp, index)
	function automatic access_result_t lfu_predict(input logic [PAGE_W-1:0] pg, input logic wr);
		access_result_t res;
		int  victim;
		bit  found;
		bit  was_valid;
		res    = '0;
		victim = 0;
		found  = 1'b0;

		access_count = access_count + 1;
		// halve all active valid counts on every eighth access (never at a wrapped zero)
		if (access_count != 0 && access_count % AGE_EVERY == 0) begin
			for (int i = 0; i < slots_active; i++) begin
				if (pg_valid[i])
					pg_uses[i] = pg_uses[i] >> 1;
			end
		end

		for (int i = 0; i < slots_active; i++) begin
			if (pg_valid[i] && pg_tag[i] == pg) begin
				hits_seen = hits_seen + 1;
				if (pg_uses[i] != 16'hFFFF)
					pg_uses[i] = pg_uses[i] + 16'd1;
				pg_stamp[i] = access_count;
				if (wr)
					pg_dirty[i] = 1'b1;
				res.hit    = 1'b1;
				res.slot   = i[SLOT_OUT_W-1:0];
				res.hits   = hits_seen;
				res.misses = misses_seen;
				return res;
			end
		end

		misses_seen = misses_seen + 1;

		if (fill_count < slots_active) begin
			for (int i = 0; i < slots_active; i++) begin
				if (!found && !pg_valid[i]) begin
					victim = i;
					found  = 1'b1;
				end
			end
		end

		if (found) begin
			place_page(victim, pg, wr);
			if (fill_count < SLOTS_N)
				fill_count++;
		end else begin
			victim = 0;
			for (int i = 1; i < slots_active; i++) begin
				if (pg_uses[i] < pg_uses[victim] ||
				    (pg_uses[i] == pg_uses[victim] && pg_stamp[i] < pg_stamp[victim]))
					victim = i;
			end
			was_valid = pg_valid[victim];
			place_page(victim, pg, wr);
			if (!was_valid && fill_count < SLOTS_N)
				fill_count++;
			res.evicted = was_valid;
		end
		res.slot   = victim[SLOT_OUT_W-1:0];
		res.hits   = hits_seen;
		res.misses = misses_seen;
		return res;
	endfunction

	// Drive one access from the falling edge; it transfers on the first rising
	// edge with busy low. start stays high afterwards so that back-to-back
	// accesses never lower and raise it within one step.
	task automatic issue_access(input logic [PAGE_W-1:0] pg, input logic wr,
	                            input logic fixed, input access_result_t want);
		access_result_t res;
		@(negedge clk);
		start        <= 1'b1;
		page_number  <= pg;
		write_access <= wr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		res = lfu_predict(pg, wr);
		outcome_q.push_back(fixed ? want : res);
	endtask

	// Register write only once the block has drained
	task automatic cfg_write(input logic [CFG_W-1:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (outcome_q.size() != 0 || busy)
			@(posedge clk);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		// zero reads as one slot, anything past the slot count as all slots
		if (v == 0)
			slots_active = 1;
		else if (v > SLOTS_N)
			slots_active = SLOTS_N;
		else
			slots_active = int'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	// Result side: every done strobe is checked against the oldest prediction
	always @(posedge clk) begin
		access_result_t exp_res;
		if (arst_n && done === 1'b1) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result with nothing expected, actual hit %0b slot %0d evicted %0b",
				         $time, hit, slot_used, evicted);
				err_count++;
			end else begin
				exp_res = outcome_q.pop_front();
				check_field("hit",        32'(exp_res.hit),     32'(hit));
				check_field("slot_used",  32'(exp_res.slot),    32'(slot_used));
				check_field("evicted",    32'(exp_res.evicted), 32'(evicted));
				check_field("hit_total",  exp_res.hits,         hit_total);
				check_field("miss_total", exp_res.misses,       miss_total);
			end
		end
	end

	initial begin
		int               ph;
		int               k;
		int               pool_lim;
		int               gap_odds;
		int               gap;
		logic [PAGE_W-1:0] pg;
		logic [CFG_W-1:0] cfg_v;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		start        = 1'b0;
		page_number  = '0;
		write_access = 1'b0;
		err_count    = 0;

		for (int i = 0; i < SLOTS_N; i++) begin
			pg_tag[i]   = '0;
			pg_valid[i] = 1'b0;
			pg_dirty[i] = 1'b0;
			pg_uses[i]  = '0;
			pg_stamp[i] = '0;
		end
		access_count = '0;
		fill_count   = 0;
		hits_seen    = '0;
		misses_seen  = '0;
		slots_active = ACTIVE_RST;

		// Directed: all-zero and all-one pages, hit on write, aging at the eighth
		// access, single slot, out-of-range register values, inactive slots
		// keeping their pages, and fills after the register grows.
		dir_rows = '{
			'{ROW_ACCESS, 5'd0,  20'h00000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 32'd0, 32'd1}},
			'{ROW_ACCESS, 5'd0,  20'h00000, 1'b1, 1'b1, '{1'b1, 4'd0, 1'b0, 32'd1, 32'd1}},
			'{ROW_ACCESS, 5'd0,  20'hFFFFF, 1'b1, 1'b1, '{1'b0, 4'd1, 1'b0, 32'd1, 32'd2}},
			'{ROW_ACCESS, 5'd0,  20'hFFFFF, 1'b0, 1'b1, '{1'b1, 4'd1, 1'b0, 32'd2, 32'd2}},
			'{ROW_ACCESS, 5'd0,  20'h80001, 1'b0, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'h7FFFE, 1'b1, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'h00000, 1'b0, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'h00000, 1'b0, 1'b0, '0},
			'{ROW_CFG,    5'd0,  20'h00000, 1'b0, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'h12345, 1'b1, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'h12345, 1'b0, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'hFFFFF, 1'b0, 1'b0, '0},
			'{ROW_CFG,    5'd31, 20'h00000, 1'b0, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'h80001, 1'b0, 1'b0, '0},
			'{ROW_CFG,    5'd3,  20'h00000, 1'b0, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'hAAAAA, 1'b1, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'h55555, 1'b0, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'hAAAAA, 1'b0, 1'b0, '0},
			'{ROW_CFG,    5'd17, 20'h00000, 1'b0, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'h0F0F0, 1'b0, 1'b0, '0},
			'{ROW_ACCESS, 5'd0,  20'hF0F0F, 1'b1, 1'b0, '0},
			'{ROW_CFG,    5'd16, 20'h00000, 1'b0, 1'b0, '0}
		};

		// Page pool gives repeat traffic so hits and LFU evictions dominate
		page_pool[0] = '0;
		page_pool[1] = '1;
		for (int i = 2; i < POOL_N; i++)
			page_pool[i] = PAGE_W'($urandom);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_N; r++) begin
			if (dir_rows[r].kind == ROW_CFG)
				cfg_write(dir_rows[r].cfg_val);
			else
				issue_access(dir_rows[r].page, dir_rows[r].wr, dir_rows[r].fixed,
				             dir_rows[r].want);
		end

		// Random phases, each under its own slot count; first ones hit the extremes
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin cfg_v = 5'd16; end
				1: begin cfg_v = 5'd1;  end
				2: begin cfg_v = 5'd31; end
				3: begin cfg_v = 5'd2;  end
				4: begin cfg_v = 5'd0;  end
				5: begin cfg_v = 5'd17; end
				default: begin cfg_v = CFG_W'($urandom_range(0, 31)); end
			endcase
			cfg_write(cfg_v);

			// pool of random size up to twice the active set plus four keeps hits and evictions going
			pool_lim = $urandom_range(1, (2 * slots_active + 4 > POOL_N) ?
			                             POOL_N : 2 * slots_active + 4);
			// no idling in the final phase; odds of zero give idle-free stretches too
			gap_odds = (ph == PHASES - 1) ? 0 : $urandom_range(0, 3);

			for (k = 0; k < PHASE_LEN; k++) begin
				if (gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
					gap = $urandom_range(1, 6);
					@(negedge clk);
					start       <= 1'b0;
					page_number <= PAGE_W'($urandom);
					repeat (gap - 1)
						@(negedge clk);
				end
				if ($urandom_range(0, 9) < 8)
					pg = page_pool[$urandom_range(0, pool_lim - 1)];
				else
					pg = PAGE_W'($urandom);
				issue_access(pg, 1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		// leave room for stray strobes after the last replacement
		repeat (40)
			@(posedge clk);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== lfu_cache_replacement.f =====
src/lfu_pkg.sv
src/lfu_ctrl.sv
src/lfu_dp.sv
src/lfu_cache_replacement.sv
tb/lfu_cache_replacement_tb.sv
